@@ hw/rtl/nll_pkg.sv @@
// ----------------------------------------------------------------------------
// nll_pkg
// Shared types, widths and codes of the nearest-location lookup block.
// ----------------------------------------------------------------------------
package nll_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 256;

   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int COORD_W   = 19;
   localparam int LO_W      = 20;
   localparam int EXT_W     = 21;
   localparam int TERM_W    = 23;
   localparam int ABS_W     = 22;
   localparam int PDIFF_W   = 21;
   localparam int AXIS_W    = 39;
   localparam int SUM_W     = 41;
   localparam int INDEX_W   = 8;
   localparam int DIST_W    = 44;
   localparam int Z_WIDEN   = 32;

   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 56;

   localparam int OFF_FIRST_X  = 0 * COORD_W;
   localparam int OFF_FIRST_Y  = 1 * COORD_W;
   localparam int OFF_FIRST_Z  = 2 * COORD_W;
   localparam int OFF_SECOND_X = 3 * COORD_W;
   localparam int OFF_SECOND_Y = 4 * COORD_W;
   localparam int OFF_SECOND_Z = 5 * COORD_W;
   localparam int OFF_POINT_X  = 6 * COORD_W;
   localparam int OFF_POINT_Y  = 7 * COORD_W;
   localparam int OFF_POINT_Z  = 8 * COORD_W;

   typedef enum logic [CMD_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_QUERY = 2'd2
   } nll_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } nll_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } nll_state_type;

   typedef struct packed {
      logic [EXT_W-1:0]       ext;
      logic signed [LO_W-1:0] hi_z;
      logic signed [LO_W-1:0] hi_y;
      logic signed [LO_W-1:0] hi_x;
      logic signed [LO_W-1:0] lo_z;
      logic signed [LO_W-1:0] lo_y;
      logic signed [LO_W-1:0] lo_x;
   } nll_entry_type;

   typedef struct packed {
      logic           wr_en;
      logic           rd_en;
      logic           scan_start;
      logic           rsp_load;
      logic           rsp_query;
      nll_status_type rsp_status;
   } nll_cmd_type;

endpackage

@@ hw/rtl/nearest_location_lookup.sv @@
// ----------------------------------------------------------------------------
// nearest_location_lookup
// Table of map locations that answers nearest-location queries by a scan.
//
// Channel   Direction  Handshake               Content
// req_      in         req_tvalid/req_tready   tuser: cmd; tdata: corners, point
// rsp_      out        rsp_tvalid/rsp_tready   tuser: status; tdata: index, dist
// csr_      in         csr_valid/csr_ready     csr_data: point_mode
//
// A clear, an add, an unused command or a query on an empty table goes
// from idle straight to the done state, which loads the output register.
// A query on a non-empty table scans it: the scan reads one entry per cycle
// from the single read port of the location RAM, and each entry then passes
// the four-stage distance pipeline before the result handoff.
// Reset is synchronous; it empties the table and clears point_mode.
// The next item is taken while a finished result still waits in the output
// register; a stalled result holds only the final handoff.
// ----------------------------------------------------------------------------
module nearest_location_lookup #(
   parameter int TABLE_DEPTH = nll_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z,
   // point_x, point_y, point_z, then zero fill.
   input  logic [nll_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd.
   input  logic [nll_pkg::CMD_W-1:0]      req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // best_index, best_distance, then zero fill.
   output logic [nll_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status.
   output logic [nll_pkg::STATUS_W-1:0]   rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_data
);

   localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   nll_pkg::nll_cmd_type cmd;
   logic [AddrW-1:0]     addr;
   logic                 pipe_busy;

   assign csr_ready = 1'b1;

   nll_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_nll_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .addr       (addr),
      .pipe_busy  (pipe_busy)
   );

   nll_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_nll_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .addr      (addr),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .pipe_busy (pipe_busy),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

@@ hw/rtl/nll_ram.sv @@
// ----------------------------------------------------------------------------
// nll_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/nll_ctrl.sv @@
// ----------------------------------------------------------------------------
// nll_ctrl
// Controller: decodes each item, keeps the entry count, steps the table scan
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module nll_ctrl #(
   parameter int TABLE_DEPTH = nll_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  req_tvalid,
   input  logic [nll_pkg::CMD_W-1:0]                             req_op,
   output logic                                                  req_tready,
   output logic                                                  rsp_tvalid,
   input  logic                                                  rsp_tready,
   output nll_pkg::nll_cmd_type                                  cmd,
   output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] addr,
   input  logic                                                  pipe_busy
);

   localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW  = $clog2(TABLE_DEPTH + 1);

   nll_pkg::nll_state_type  state_ff, state_in;
   nll_pkg::nll_status_type status_ff, status_in;
   logic [CntW-1:0]         count_ff, count_in;
   logic [AddrW-1:0]        scan_ff, scan_in;
   logic                    query_ff, query_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CntW-1:0]         last_w;
   logic                    full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nll_pkg::ST_IDLE;
         status_ff    <= nll_pkg::STAT_OK;
         count_ff     <= '0;
         scan_ff      <= '0;
         query_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         query_ff     <= query_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign last_w = count_ff - CntW'(1);
   assign full   = (count_ff == CntW'(TABLE_DEPTH));

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      query_in       = query_ff;
      req_tready     = 1'b0;
      addr           = scan_ff;
      cmd.wr_en      = 1'b0;
      cmd.rd_en      = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.rsp_load   = 1'b0;
      cmd.rsp_query  = query_ff;
      cmd.rsp_status = status_ff;

      unique case (state_ff)
         nll_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in  = nll_pkg::ST_DONE;
               status_in = nll_pkg::STAT_OK;
               query_in  = 1'b0;
               unique case (nll_pkg::nll_op_type'(req_op))
                  nll_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  nll_pkg::OP_ADD: begin
                     if (full) begin
                        status_in = nll_pkg::STAT_FULL;
                     end else begin
                        cmd.wr_en = 1'b1;
                        addr      = count_ff[AddrW-1:0];
                        count_in  = count_ff + CntW'(1);
                     end
                  end
                  nll_pkg::OP_QUERY: begin
                     if (count_ff == '0) begin
                        status_in = nll_pkg::STAT_EMPTY;
                     end else begin
                        cmd.scan_start = 1'b1;
                        query_in       = 1'b1;
                        scan_in        = '0;
                        state_in       = nll_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     status_in = nll_pkg::STAT_OK;
                  end
               endcase
            end
         end
         nll_pkg::ST_SCAN: begin
            cmd.rd_en = 1'b1;
            scan_in   = scan_ff + AddrW'(1);
            if (scan_ff == last_w[AddrW-1:0]) begin
               state_in = nll_pkg::ST_DRAIN;
            end
         end
         nll_pkg::ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = nll_pkg::ST_DONE;
            end
         end
         nll_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = nll_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nll_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ hw/rtl/nll_datapath.sv @@
// ----------------------------------------------------------------------------
// nll_datapath
// Datapath: corner ordering on add, the location table, a four-stage distance
// pipeline for the scan, the running best entry and the result register.
// ----------------------------------------------------------------------------
module nll_datapath #(
   parameter int TABLE_DEPTH = nll_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  nll_pkg::nll_cmd_type                                  cmd,
   input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] addr,
   input  logic [nll_pkg::REQ_DATA_W-1:0]                        req_tdata,
   input  logic                                                  csr_valid,
   input  logic                                                  csr_data,
   output logic                                                  pipe_busy,
   output logic [nll_pkg::RSP_DATA_W-1:0]                        rsp_tdata,
   output logic [nll_pkg::STATUS_W-1:0]                          rsp_tuser
);

   localparam int AddrW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CoordW = nll_pkg::COORD_W;
   localparam int LoW    = nll_pkg::LO_W;
   localparam int ExtW   = nll_pkg::EXT_W;
   localparam int TermW  = nll_pkg::TERM_W;
   localparam int AbsW   = nll_pkg::ABS_W;
   localparam int PdW    = nll_pkg::PDIFF_W;
   localparam int AxisW  = nll_pkg::AXIS_W;
   localparam int SumW   = nll_pkg::SUM_W;
   localparam int IdxW   = nll_pkg::INDEX_W;
   localparam int DistW  = nll_pkg::DIST_W;
   localparam int EntryW = $bits(nll_pkg::nll_entry_type);

   // Add path: order the corners and form the stored entry.
   logic signed [CoordW-1:0] first_c [3];
   logic signed [CoordW-1:0] second_c [3];
   logic signed [LoW-1:0]    lo_w [3];
   logic signed [LoW-1:0]    hi_w [3];
   logic [ExtW-1:0]          ext_w;
   nll_pkg::nll_entry_type   wr_entry;

   assign first_c[0]  = $signed(req_tdata[nll_pkg::OFF_FIRST_X +: CoordW]);
   assign first_c[1]  = $signed(req_tdata[nll_pkg::OFF_FIRST_Y +: CoordW]);
   assign first_c[2]  = $signed(req_tdata[nll_pkg::OFF_FIRST_Z +: CoordW]);
   assign second_c[0] = $signed(req_tdata[nll_pkg::OFF_SECOND_X +: CoordW]);
   assign second_c[1] = $signed(req_tdata[nll_pkg::OFF_SECOND_Y +: CoordW]);
   assign second_c[2] = $signed(req_tdata[nll_pkg::OFF_SECOND_Z +: CoordW]);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (first_c[k] > second_c[k]) begin
            lo_w[k] = LoW'(second_c[k]);
            hi_w[k] = LoW'(first_c[k]);
         end else begin
            lo_w[k] = LoW'(first_c[k]);
            hi_w[k] = LoW'(second_c[k]);
         end
      end
   end

   assign ext_w = ExtW'(hi_w[0] - lo_w[0]) + ExtW'(hi_w[1] - lo_w[1])
                + ExtW'(hi_w[2] - lo_w[2]);

   // The extent sum is taken before z is widened.
   assign wr_entry.ext  = ext_w;
   assign wr_entry.lo_x = lo_w[0];
   assign wr_entry.lo_y = lo_w[1];
   assign wr_entry.lo_z = lo_w[2] - LoW'(nll_pkg::Z_WIDEN);
   assign wr_entry.hi_x = hi_w[0];
   assign wr_entry.hi_y = hi_w[1];
   assign wr_entry.hi_z = hi_w[2] + LoW'(nll_pkg::Z_WIDEN);

   logic [EntryW-1:0]      rd_data;
   nll_pkg::nll_entry_type rd_entry;

   nll_ram #(
      .WIDTH (EntryW),
      .DEPTH (TABLE_DEPTH)
   ) u_nll_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   assign rd_entry = nll_pkg::nll_entry_type'(rd_data);

   // Mode register and query point.
   logic                     point_mode_ff;
   logic signed [CoordW-1:0] point_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         point_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         point_mode_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         point_ff[0] <= $signed(req_tdata[nll_pkg::OFF_POINT_X +: CoordW]);
         point_ff[1] <= $signed(req_tdata[nll_pkg::OFF_POINT_Y +: CoordW]);
         point_ff[2] <= $signed(req_tdata[nll_pkg::OFF_POINT_Z +: CoordW]);
      end
   end

   // Stage 0: table read.
   logic             rd_v_ff;
   logic [AddrW-1:0] rd_idx_ff;

   // Stage 1: per-axis corner terms.
   logic                 s1_v_ff;
   logic [AddrW-1:0]     s1_idx_ff;
   logic [ExtW-1:0]      s1_ext_ff;
   logic [AbsW-1:0]      s1_a_ff [3];
   logic [AbsW-1:0]      s1_b_ff [3];
   logic signed [PdW-1:0] s1_pd_ff [3];
   logic [AbsW-1:0]      s1_a_in [3];
   logic [AbsW-1:0]      s1_b_in [3];
   logic signed [PdW-1:0] s1_pd_in [3];
   logic signed [LoW-1:0] rd_lo [3];
   logic signed [LoW-1:0] rd_hi [3];

   // Stage 2: per-axis distance.
   logic                  s2_v_ff;
   logic [AddrW-1:0]      s2_idx_ff;
   logic [ExtW-1:0]       s2_ext_ff;
   logic [AxisW-1:0]      s2_axis_ff [3];
   logic [AxisW-1:0]      s2_axis_in [3];
   logic signed [2*PdW-1:0] sq [3];

   // Stage 3: entry distance.
   logic             s3_v_ff;
   logic [AddrW-1:0] s3_idx_ff;
   logic [SumW-1:0]  s3_dist_ff;
   logic [SumW-1:0]  s3_dist_in;

   // Running best.
   logic             have_ff;
   logic             stop_ff;
   logic [SumW-1:0]  best_dist_ff;
   logic [AddrW-1:0] best_idx_ff;
   logic             take;

   assign rd_lo[0] = $signed(rd_entry.lo_x);
   assign rd_lo[1] = $signed(rd_entry.lo_y);
   assign rd_lo[2] = $signed(rd_entry.lo_z);
   assign rd_hi[0] = $signed(rd_entry.hi_x);
   assign rd_hi[1] = $signed(rd_entry.hi_y);
   assign rd_hi[2] = $signed(rd_entry.hi_z);

   always_comb begin
      logic signed [TermW-1:0] p_t;
      logic signed [TermW-1:0] da;
      logic signed [TermW-1:0] db;
      for (int k = 0; k < 3; k++) begin
         p_t = TermW'(point_ff[k]);
         da  = $signed({rd_lo[k], 3'b000}) - p_t;
         db  = $signed({rd_hi[k], 3'b000}) - p_t;
         s1_a_in[k]  = da[TermW-1] ? AbsW'(-da) : AbsW'(da);
         s1_b_in[k]  = db[TermW-1] ? AbsW'(-db) : AbsW'(db);
         s1_pd_in[k] = PdW'(point_ff[k]) - PdW'(rd_lo[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq[k] = s1_pd_ff[k] * s1_pd_ff[k];
         if (point_mode_ff) begin
            s2_axis_in[k] = sq[k][AxisW-1:0];
         end else begin
            s2_axis_in[k] = AxisW'(s1_a_ff[k]) + AxisW'(s1_b_ff[k]);
         end
      end
   end

   // Box distance cannot go below zero: both corners bound each axis span.
   assign s3_dist_in = SumW'(s2_axis_ff[0]) + SumW'(s2_axis_ff[1]) + SumW'(s2_axis_ff[2])
                     - (point_mode_ff ? SumW'(0) : SumW'({s2_ext_ff, 3'b000}));

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.rd_en;
         s1_v_ff <= rd_v_ff;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= addr;
      s1_idx_ff  <= rd_idx_ff;
      s1_ext_ff  <= rd_entry.ext;
      s1_a_ff    <= s1_a_in;
      s1_b_ff    <= s1_b_in;
      s1_pd_ff   <= s1_pd_in;
      s2_idx_ff  <= s1_idx_ff;
      s2_ext_ff  <= s1_ext_ff;
      s2_axis_ff <= s2_axis_in;
      s3_idx_ff  <= s2_idx_ff;
      s3_dist_ff <= s3_dist_in;
   end

   assign take = s3_v_ff && !stop_ff && (!have_ff || (s3_dist_ff < best_dist_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         stop_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         have_ff <= 1'b0;
         stop_ff <= 1'b0;
      end else if (take) begin
         have_ff <= 1'b1;
         stop_ff <= !point_mode_ff && (s3_dist_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_dist_ff <= s3_dist_ff;
         best_idx_ff  <= s3_idx_ff;
      end
   end

   assign pipe_busy = rd_v_ff | s1_v_ff | s2_v_ff | s3_v_ff;

   // Result register.
   logic [nll_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [nll_pkg::STATUS_W-1:0]   rsp_user_ff;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_user_ff <= cmd.rsp_status;
         if (cmd.rsp_query) begin
            rsp_data_ff <= nll_pkg::RSP_DATA_W'({DistW'(best_dist_ff), IdxW'(best_idx_ff)});
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

@@ hw/rtl/nll_checker.sv @@
// ----------------------------------------------------------------------------
// nll_checker
// Port-level assertions for the nearest-location lookup block.
// ----------------------------------------------------------------------------
module nll_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [nll_pkg::CMD_W-1:0]      req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [nll_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [nll_pkg::STATUS_W-1:0]   rsp_tuser
);

   // The block works on one item at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while the previous one was still in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == nll_pkg::STAT_OK || rsp_tuser == nll_pkg::STAT_FULL
                      || rsp_tuser == nll_pkg::STAT_EMPTY))
      else $error("result carries an unknown status");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != nll_pkg::STAT_OK |-> rsp_tdata == '0)
      else $error("error result carries index or distance");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // The command code is known whenever an item is offered.
   a_cmd_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid |-> !$isunknown(req_tuser))
      else $error("item offered with an unknown command");

endmodule

bind nearest_location_lookup nll_checker u_nll_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the nearest-location lookup block. A short table of
// directed items runs first: an empty table, the unused command, and
// corners at the coordinate extremes in both distance modes. Random phases
// follow, each with an optional mode change, a table of random or clustered
// locations, and queries mostly aimed near stored entries. Every result is
// checked field by field against a predictor holding its own location table.
// ----------------------------------------------------------------------------
module testbench;
   import nll_pkg::*;

   localparam int ITEM_TARGET  = 1300;
   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int N_DIRECTED   = 22;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic signed [COORD_W-1:0] C_MAX  = 19'sh3FFFF;
   localparam logic signed [COORD_W-1:0] C_MIN  = 19'sh40000;
   localparam logic signed [COORD_W-1:0] C_ZERO = 19'sd0;

   typedef enum logic {
      ROW_CMD,
      ROW_MODE
   } row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CMD_W-1:0]          cmd;
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] az;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic signed [COORD_W-1:0] bz;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] pz;
      logic                      mode;
      logic                      typed;
      logic [STATUS_W-1:0]       status;
      logic [INDEX_W-1:0]        index;
      logic [DIST_W-1:0]         distance;
   } script_row_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [DIST_W-1:0]   distance;
   } lookup_result_type;

   localparam script_row_type DIRECTED [N_DIRECTED] = '{
      '{ROW_CMD, OP_QUERY, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b1, STAT_EMPTY, 8'd0, 44'd0},
      '{ROW_CMD, CMD_UNUSED, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
        C_MAX, C_MAX, C_MAX, 1'b0, 1'b1, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_CLEAR, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
        C_MIN, C_MIN, C_MIN, 1'b0, 1'b1, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_ADD, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
        C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b1, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_ADD, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
        C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b1, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_ADD, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b1, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_ADD, 19'sd100, -19'sd50, 19'sd7, 19'sd90, -19'sd40, -19'sd7,
        C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b1, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_QUERY, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_QUERY, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        C_MAX, C_MAX, C_MAX, 1'b0, 1'b0, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_QUERY, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        C_MIN, C_MIN, C_MIN, 1'b0, 1'b0, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_QUERY, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        19'sd760, -19'sd360, C_ZERO, 1'b0, 1'b0, STAT_OK, 8'd0, 44'd0},
      '{ROW_MODE, OP_CLEAR, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        C_ZERO, C_ZERO, C_ZERO, 1'b1, 1'b0, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_QUERY, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_QUERY, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        C_MAX, C_MAX, C_MAX, 1'b0, 1'b0, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_QUERY, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        C_MIN, C_MIN, C_MIN, 1'b0, 1'b0, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_ADD, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
        C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b1, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_QUERY, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        C_MAX, C_MAX, C_MAX, 1'b0, 1'b0, STAT_OK, 8'd0, 44'd0},
      '{ROW_MODE, OP_CLEAR, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b0, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_CLEAR, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b1, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_QUERY, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b1, STAT_EMPTY, 8'd0, 44'd0},
      '{ROW_CMD, OP_ADD, -19'sd1, -19'sd1, -19'sd1, -19'sd3, 19'sd2, -19'sd1,
        C_ZERO, C_ZERO, C_ZERO, 1'b0, 1'b1, STAT_OK, 8'd0, 44'd0},
      '{ROW_CMD, OP_QUERY, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
        C_MIN, C_MIN, C_MIN, 1'b0, 1'b0, STAT_OK, 8'd0, 44'd0}
   };

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic                  csr_data   = 1'b0;

   logic                  point_mode_now = 1'b0;
   int                    stored_count   = 0;
   logic signed [21:0]    stored_low  [TABLE_DEPTH_DEFAULT][3];
   logic signed [21:0]    stored_high [TABLE_DEPTH_DEFAULT][3];
   logic [23:0]           stored_extent [TABLE_DEPTH_DEFAULT];
   lookup_result_type     pending_results [$];

   int n_items       = 0;
   int n_queries     = 0;
   int n_adds        = 0;
   int n_dropped     = 0;
   int n_empty       = 0;
   int n_mode_writes = 0;
   int n_errors      = 0;
   int n_cycles      = 0;
   int src_idle_pct  = 0;
   int sink_idle_pct = 0;

   nearest_location_lookup u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > LIMIT_CYCLES) begin
         $display("%0t: timeout after %0d cycles", $time, n_cycles);
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(0, 99) >= sink_idle_pct);
   end

   always @(posedge clock) begin : check_results
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, status %0d index %0d distance %0d",
                     $time, rsp_tuser, rsp_tdata[INDEX_W-1:0], rsp_tdata[INDEX_W +: DIST_W]);
            n_errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_tuser);
               n_errors++;
            end
            if (rsp_tdata[INDEX_W-1:0] !== want.index) begin
               $display("%0t: index expected %0d, got %0d",
                        $time, want.index, rsp_tdata[INDEX_W-1:0]);
               n_errors++;
            end
            if (rsp_tdata[INDEX_W +: DIST_W] !== want.distance) begin
               $display("%0t: distance expected %0d, got %0d",
                        $time, want.distance, rsp_tdata[INDEX_W +: DIST_W]);
               n_errors++;
            end
         end
      end
   end

   function automatic lookup_result_type predict_lookup(input script_row_type r);
      lookup_result_type res;
      longint a [3];
      longint b [3];
      longint p [3];
      longint lo, hi, ext, s, d, best, q;
      int     e, bi;
      bit     found;
      res  = '0;
      a[0] = r.ax;
      a[1] = r.ay;
      a[2] = r.az;
      b[0] = r.bx;
      b[1] = r.by;
      b[2] = r.bz;
      p[0] = r.px;
      p[1] = r.py;
      p[2] = r.pz;
      case (r.cmd)
         OP_CLEAR: begin
            stored_count = 0;
         end
         OP_ADD: begin
            if (stored_count >= TABLE_DEPTH_DEFAULT) begin
               res.status = STAT_FULL;
            end else begin
               e   = stored_count;
               ext = 0;
               for (int k = 0; k < 3; k++) begin
                  lo  = (a[k] > b[k]) ? b[k] : a[k];
                  hi  = (a[k] > b[k]) ? a[k] : b[k];
                  ext = ext + hi - lo;
                  // The z axis is widened only after the extent sum is taken.
                  if (k == 2) begin
                     lo = lo - Z_WIDEN;
                     hi = hi + Z_WIDEN;
                  end
                  stored_low[e][k]  = 22'(lo);
                  stored_high[e][k] = 22'(hi);
               end
               stored_extent[e] = 24'(ext);
               stored_count++;
            end
         end
         OP_QUERY: begin
            if (stored_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               found = 1'b0;
               best  = 0;
               bi    = 0;
               for (int i = 0; i < stored_count; i++) begin
                  if (point_mode_now) begin
                     d = 0;
                     for (int k = 0; k < 3; k++) begin
                        q = p[k] - longint'(stored_low[i][k]);
                        d = d + q * q;
                     end
                  end else begin
                     s = -8 * longint'(stored_extent[i]);
                     for (int k = 0; k < 3; k++) begin
                        q = 8 * longint'(stored_low[i][k]);
                        s = s + ((q > p[k]) ? q - p[k] : p[k] - q);
                        q = 8 * longint'(stored_high[i][k]);
                        s = s + ((q > p[k]) ? q - p[k] : p[k] - q);
                     end
                     d = (s < 0) ? 0 : s;
                     if (d == 0) begin
                        best  = 0;
                        bi    = i;
                        found = 1'b1;
                        break;
                     end
                  end
                  if (!found || d < best) begin
                     best  = d;
                     bi    = i;
                     found = 1'b1;
                  end
               end
               res.index    = INDEX_W'(bi);
               res.distance = DIST_W'(best);
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
      if (v > longint'(C_MAX)) return C_MAX;
      if (v < longint'(C_MIN)) return C_MIN;
      return COORD_W'(v);
   endfunction

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      drain_results();
      csr_data  <= mode;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      point_mode_now = mode;
      n_mode_writes++;
   endtask

   task automatic drive_request(input script_row_type r);
      lookup_result_type res;
      if (n_items < ITEM_TARGET / 3) begin
         src_idle_pct  = 34;
         sink_idle_pct = 84;
      end else if (n_items < 2 * ITEM_TARGET / 3) begin
         src_idle_pct  = 84;
         sink_idle_pct = 34;
      end else begin
         src_idle_pct  = 0;
         sink_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.cmd;
      req_tdata  <= REQ_DATA_W'({r.pz, r.py, r.px, r.bz, r.by, r.bx, r.az, r.ay, r.ax});
      do @(posedge clock); while (!req_tready);
      res = predict_lookup(r);
      if (r.typed) begin
         res.status   = r.status;
         res.index    = r.index;
         res.distance = r.distance;
      end
      pending_results.push_back(res);
      n_items++;
      if (r.cmd == OP_QUERY) n_queries++;
      if (r.cmd == OP_ADD) n_adds++;
      if (res.status == STAT_FULL) n_dropped++;
      if (res.status == STAT_EMPTY) n_empty++;
   endtask

   task automatic run_row(input script_row_type r);
      if (r.kind == ROW_MODE) write_mode(r.mode);
      else drive_request(r);
   endtask

   // One phase: an optional mode change, usually a clear, a run of adds and
   // then queries, mostly aimed near stored entries. Noise items of any
   // command with random fields are mixed in throughout.
   task automatic random_phase();
      script_row_type r;
      logic signed [COORD_W-1:0] pt [3];
      longint center [3];
      longint lo, hi;
      int spread, n_add, n_look, j;
      bit wide;
      if ($urandom_range(0, 1) == 1) write_mode(1'($urandom_range(0, 1)));
      wide   = ($urandom_range(0, 2) == 0);
      spread = $urandom_range(4, 4000);
      for (int k = 0; k < 3; k++) center[k] = longint'($signed(COORD_W'($urandom())));
      r      = '0;
      r.kind = ROW_CMD;
      if ($urandom_range(0, 99) < 85) begin
         r.cmd = OP_CLEAR;
         drive_request(r);
      end
      n_add  = ($urandom_range(0, 11) == 0) ? TABLE_DEPTH_DEFAULT + $urandom_range(1, 4)
                                            : $urandom_range(1, 24);
      n_look = $urandom_range(2, 10);
      for (int i = 0; i < n_add + n_look; i++) begin
         r      = '0;
         r.kind = ROW_CMD;
         if ($urandom_range(0, 99) < 6) begin
            r.cmd = CMD_UNUSED & 2'($urandom());
            r.ax  = COORD_W'($urandom());
            r.ay  = COORD_W'($urandom());
            r.az  = COORD_W'($urandom());
            r.bx  = COORD_W'($urandom());
            r.by  = COORD_W'($urandom());
            r.bz  = COORD_W'($urandom());
            r.px  = COORD_W'($urandom());
            r.py  = COORD_W'($urandom());
            r.pz  = COORD_W'($urandom());
         end else if (i < n_add) begin
            r.cmd = OP_ADD;
            for (int k = 0; k < 3; k++) begin
               pt[k] = wide ? COORD_W'($urandom())
                            : clamp_coord(center[k] + $urandom_range(0, 2 * spread) - spread);
            end
            r.ax = pt[0];
            r.ay = pt[1];
            r.az = pt[2];
            if (point_mode_now && $urandom_range(0, 99) < 70) begin
               r.bx = pt[0];
               r.by = pt[1];
               r.bz = pt[2];
            end else begin
               for (int k = 0; k < 3; k++) begin
                  pt[k] = wide ? COORD_W'($urandom())
                               : clamp_coord(center[k] + $urandom_range(0, 2 * spread) - spread);
               end
               r.bx = pt[0];
               r.by = pt[1];
               r.bz = pt[2];
            end
         end else begin
            r.cmd = OP_QUERY;
            if (stored_count > 0 && $urandom_range(0, 99) < 70) begin
               j = $urandom_range(0, stored_count - 1);
               for (int k = 0; k < 3; k++) begin
                  lo    = 8 * longint'(stored_low[j][k]);
                  hi    = 8 * longint'(stored_high[j][k]);
                  pt[k] = clamp_coord(lo + $urandom_range(0, int'(hi - lo))
                                      + $urandom_range(0, 32) - 16);
               end
            end else begin
               for (int k = 0; k < 3; k++) pt[k] = COORD_W'($urandom());
            end
            r.px = pt[0];
            r.py = pt[1];
            r.pz = pt[2];
         end
         drive_request(r);
      end
      if ($urandom_range(0, 3) == 0) drain_results();
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < N_DIRECTED; i++) run_row(DIRECTED[i]);
      while (n_items < ITEM_TARGET) random_phase();
      drain_results();
      repeat (TABLE_DEPTH_DEFAULT + 16) @(posedge clock);
      $display("Ran %0d items: %0d queries, %0d adds, %0d adds dropped on a full table,",
               n_items, n_queries, n_adds, n_dropped);
      $display("%0d queries on an empty table, %0d mode writes, %0d mismatches.",
               n_empty, n_mode_writes, n_errors);
      if (n_errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ nearest_location_lookup.f @@
hw/rtl/nll_pkg.sv
hw/rtl/nll_ram.sv
hw/rtl/nll_ctrl.sv
hw/rtl/nll_datapath.sv
hw/rtl/nearest_location_lookup.sv
hw/rtl/nll_checker.sv
tb/testbench.sv
